>>> sv/pcma_pkg.sv
// Package for the PWM capture moving-average unit: payload structs, widths,
// constants and the front-to-back command type. No dependencies.
package pcma_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int TIME_BITS  = 24;
  localparam int SLOT_BITS  = $clog2(WINDOW_MAX);
  localparam int WIN_BITS   = 5;
  localparam int SUM_BITS   = TIME_BITS + SLOT_BITS;
  localparam int DUTY_BITS  = 17;
  localparam int VEL_BITS   = 40;

  localparam logic EDGE_RISE = 1'b0;
  localparam logic EDGE_FALL = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [TIME_BITS-1:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]        period_us;
    logic [TIME_BITS-1:0]        avg_period_us;
    logic [TIME_BITS-1:0]        pulse_us;
    logic [TIME_BITS-1:0]        avg_pulse_us;
    logic [DUTY_BITS-1:0]        avg_duty;
    logic signed [VEL_BITS-1:0]  duty_velocity;
  } out_item_t;

  // command from front to back: classified edge plus effective window
  typedef struct packed {
    logic                 fall;
    logic [TIME_BITS-1:0] t;
    logic [WIN_BITS-1:0]  win;
  } cmd_t;

endpackage

>>> sv/pcma_front.sv
// Front end of the PWM capture unit: accepts requests, clamps the window
// and pushes commands into a two-entry queue. Depends on pcma_pkg.
module pcma_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  pcma_pkg::in_item_t       in_data,
  input  logic [pcma_pkg::WIN_BITS-1:0] win_cfg,
  output logic                     q_valid,
  output pcma_pkg::cmd_t           q_data,
  input  logic                     q_pop
);

  pcma_pkg::cmd_t q_r [2];
  pcma_pkg::cmd_t q_nxt_entry;
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic push;
  logic [pcma_pkg::WIN_BITS-1:0] eff_win;

  always_comb begin
    if (win_cfg == '0) begin
      eff_win = pcma_pkg::WIN_BITS'(1);
    end else if (win_cfg > pcma_pkg::WIN_BITS'(pcma_pkg::WINDOW_MAX)) begin
      eff_win = pcma_pkg::WIN_BITS'(pcma_pkg::WINDOW_MAX);
    end else begin
      eff_win = win_cfg;
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_r[rd_r];

  assign q_nxt_entry.fall = in_data.func;
  assign q_nxt_entry.t    = in_data.elapsed_us;
  assign q_nxt_entry.win  = eff_win;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) begin
      q_r[wr_r] <= q_nxt_entry;
    end
  end

endmodule

>>> sv/pcma_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, unsigned.
// Used by the back end for averages, duty and velocity. Uses no package.
module pcma_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] sh;

  assign sh   = {rem_r[31:0], q_r[63]};
  assign done = busy_r && (cnt_r == 7'd0);
  assign quo  = q_r;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 7'd1;
        if (sh >= {1'b0, den_r}) begin
          rem_nxt = sh - {1'b0, den_r};
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = sh;
          q_nxt   = {q_r[62:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

endmodule

>>> sv/pcma_back.sv
// Back end of the PWM capture unit: ring update, averages, duty and velocity
// through a shared divider, plus the output register. Depends on pcma_pkg, pcma_div.
module pcma_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  pcma_pkg::cmd_t     q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pcma_pkg::out_item_t out_data
);

  localparam int TB = pcma_pkg::TIME_BITS;
  localparam int SB = pcma_pkg::SLOT_BITS;
  localparam int MB = pcma_pkg::SUM_BITS;
  localparam int DB = pcma_pkg::DUTY_BITS;
  localparam int VB = pcma_pkg::VEL_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AVG  = 3'd1;
  localparam logic [2:0] ST_DUTY = 3'd2;
  localparam logic [2:0] ST_VEL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic [TB-1:0] per_ring_r [pcma_pkg::WINDOW_MAX];
  logic [TB-1:0] pul_ring_r [pcma_pkg::WINDOW_MAX];
  logic [MB-1:0] per_sum_r, pul_sum_r, sum_new;
  logic [SB-1:0] slot_r;
  logic [TB-1:0] last_per_r, last_pul_r, mean_per_r, mean_pul_r;
  logic [DB-1:0] duty_r, prior_r;
  logic signed [VB-1:0] vel_r;
  pcma_pkg::cmd_t cmd_r;
  logic neg_r;
  logic out_valid_r;
  pcma_pkg::out_item_t out_r;

  logic        dv_start;
  logic [63:0] dv_num;
  logic [31:0] dv_den;
  logic        dv_done;
  logic [63:0] dv_quo;

  logic [TB-1:0] avg_sat;
  logic [DB-1:0] duty_sat;
  logic [DB:0]   diff_abs;
  logic          diff_neg;
  logic signed [VB-1:0] vel_sat;
  logic [TB-1:0] old_ent;
  logic [pcma_pkg::WIN_BITS-1:0] slot_inc;

  pcma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  assign old_ent = cmd_r.fall ? pul_ring_r[slot_r] : per_ring_r[slot_r];
  assign sum_new = (cmd_r.fall ? pul_sum_r : per_sum_r) - MB'(old_ent) + MB'(cmd_r.t);
  assign avg_sat = (dv_quo > 64'((1 << TB) - 1)) ? '1 : dv_quo[TB-1:0];
  assign duty_sat = (dv_quo > 64'(65536)) ? DB'(65536) : dv_quo[DB-1:0];
  assign diff_neg = duty_sat < prior_r;
  assign diff_abs = diff_neg ? (DB+1)'(prior_r - duty_sat) : (DB+1)'(duty_sat - prior_r);
  assign slot_inc = pcma_pkg::WIN_BITS'(slot_r) + 1'b1;

  always_comb begin
    if (dv_quo > 64'((64'd1 << (VB - 1)) - 1)) begin
      vel_sat = neg_r ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
    end else begin
      vel_sat = neg_r ? -$signed(dv_quo[VB-1:0]) : $signed(dv_quo[VB-1:0]);
    end
  end

  always_comb begin
    st_nxt   = st_r;
    q_pop    = 1'b0;
    dv_start = 1'b0;
    dv_num   = 64'(sum_new);
    dv_den   = 32'(cmd_r.win);
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          st_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        dv_start = 1'b1;
        st_nxt   = ST_AVG;
      end
      ST_AVG: begin
        if (dv_done) begin
          if (cmd_r.fall && mean_per_r != '0) begin
            dv_start = 1'b1;
            dv_num   = 64'({avg_sat, 16'd0});
            dv_den   = 32'(mean_per_r);
            st_nxt   = ST_DUTY;
          end else begin
            st_nxt = ST_OUT;
          end
        end
      end
      ST_DUTY: begin
        if (dv_done) begin
          dv_start = 1'b1;
          dv_num   = 64'(diff_abs) * 64'd1000000;
          dv_den   = 32'(mean_per_r);
          st_nxt   = ST_VEL;
        end
      end
      ST_VEL: begin
        if (dv_done) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      per_sum_r   <= '0;
      pul_sum_r   <= '0;
      slot_r      <= '0;
      last_per_r  <= '0;
      last_pul_r  <= '0;
      mean_per_r  <= '0;
      mean_pul_r  <= '0;
      duty_r      <= '0;
      prior_r     <= '0;
      vel_r       <= '0;
      for (int i = 0; i < pcma_pkg::WINDOW_MAX; i++) begin
        per_ring_r[i] <= '0;
        pul_ring_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_WAIT) begin
        if (cmd_r.fall) begin
          pul_sum_r          <= sum_new;
          pul_ring_r[slot_r] <= cmd_r.t;
          last_pul_r         <= cmd_r.t;
        end else begin
          per_sum_r          <= sum_new;
          per_ring_r[slot_r] <= cmd_r.t;
          last_per_r         <= cmd_r.t;
        end
      end
      if (st_r == ST_AVG && dv_done) begin
        if (cmd_r.fall) begin
          mean_pul_r <= avg_sat;
          if (mean_per_r == '0) begin
            duty_r  <= '0;
            prior_r <= '0;
            vel_r   <= '0;
          end
        end else begin
          mean_per_r <= avg_sat;
        end
      end
      if (st_r == ST_DUTY && dv_done) begin
        duty_r <= duty_sat;
        neg_r  <= diff_neg;
      end
      if (st_r == ST_VEL && dv_done) begin
        vel_r   <= vel_sat;
        prior_r <= duty_r;
      end
      if (st_r == ST_OUT && st_nxt == ST_IDLE) begin
        out_valid_r <= 1'b1;
        out_r <= '{period_us: last_per_r, avg_period_us: mean_per_r,
                   pulse_us: last_pul_r, avg_pulse_us: mean_pul_r,
                   avg_duty: duty_r, duty_velocity: vel_r};
        if (cmd_r.fall) begin
          slot_r <= (slot_inc >= cmd_r.win) ? '0 : slot_inc[SB-1:0];
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (q_pop) begin
      cmd_r <= q_data;
    end
  end

endmodule

>>> sv/pwm_capture_moving_average_unit.sv
// PWM capture unit with windowed moving averages of period and pulse width,
// average duty (Q1.16) and its velocity per second (Q23.16). One shared
// 64-step bit-serial divider computes the average, then, on a falling edge
// with a nonzero average period, duty and velocity. A two-entry queue in
// front accepts requests while the back end works, and an output register
// holds the result until taken.
module pwm_capture_moving_average_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pcma_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pcma_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [pcma_pkg::WIN_BITS-1:0]     cfg_wdata
);

  logic [pcma_pkg::WIN_BITS-1:0] win_r;
  logic           q_valid, q_pop;
  pcma_pkg::cmd_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= pcma_pkg::WIN_BITS'(16);
    end else if (cfg_we) begin
      win_r <= cfg_wdata;
    end
  end

  pcma_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .win_cfg  (win_r),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  pcma_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> tb/pwm_capture_moving_average_unit_tb.sv
// Testbench for pwm_capture_moving_average_unit: random PWM edge requests with
// bursty sending and random output stalls, checked against an in-bench predictor.
// Depends on pcma_pkg and the unit RTL.
`timescale 1ns / 100ps

module pwm_capture_moving_average_unit_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pcma_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pcma_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [pcma_pkg::WIN_BITS-1:0] cfg_wdata = '0;

  pwm_capture_moving_average_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [pcma_pkg::TIME_BITS-1:0] per_ring [pcma_pkg::WINDOW_MAX];
  logic [pcma_pkg::TIME_BITS-1:0] pul_ring [pcma_pkg::WINDOW_MAX];
  longint unsigned per_total, pul_total, last_per, last_pul, avg_per, avg_pul;
  int unsigned slot, win_reg, duty_now, duty_prev;
  longint vel_now;

  pcma_pkg::in_item_t pending_edges[$];
  pcma_pkg::out_item_t expected_results[$];
  int errors = 0;
  longint cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_mode = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int unsigned eff_win();
    if (win_reg == 0) return 1;
    if (win_reg > pcma_pkg::WINDOW_MAX) return pcma_pkg::WINDOW_MAX;
    return win_reg;
  endfunction

  function automatic void predict_edge(input pcma_pkg::in_item_t req);
    pcma_pkg::out_item_t r;
    longint unsigned a, d;
    longint diff, v;
    int unsigned s;
    s = slot % pcma_pkg::WINDOW_MAX;
    if (req.func == pcma_pkg::EDGE_RISE) begin
      last_per = req.elapsed_us;
      per_total = per_total - per_ring[s] + req.elapsed_us;
      per_ring[s] = req.elapsed_us;
      a = per_total / eff_win();
      avg_per = (a > 64'hFFFFFF) ? 64'hFFFFFF : a;
    end else begin
      last_pul = req.elapsed_us;
      pul_total = pul_total - pul_ring[s] + req.elapsed_us;
      pul_ring[s] = req.elapsed_us;
      a = pul_total / eff_win();
      avg_pul = (a > 64'hFFFFFF) ? 64'hFFFFFF : a;
      if (avg_per == 0) begin
        duty_now = 0;
        vel_now = 0;
      end else begin
        d = (avg_pul * 65536) / avg_per;
        duty_now = 32'((d > 65536) ? 64'd65536 : d);
        diff = longint'(duty_now) - longint'(duty_prev);
        v = (diff * 1000000) / longint'(avg_per);
        if (v > 64'sd549755813887) v = 64'sd549755813887;
        if (v < -64'sd549755813888) v = -64'sd549755813888;
        vel_now = v;
      end
      duty_prev = duty_now;
      slot++;
      if (slot >= eff_win()) slot = 0;
    end
    r.period_us = pcma_pkg::TIME_BITS'(last_per);
    r.avg_period_us = pcma_pkg::TIME_BITS'(avg_per);
    r.pulse_us = pcma_pkg::TIME_BITS'(last_pul);
    r.avg_pulse_us = pcma_pkg::TIME_BITS'(avg_pul);
    r.avg_duty = pcma_pkg::DUTY_BITS'(duty_now);
    r.duty_velocity = pcma_pkg::VEL_BITS'(vel_now);
    expected_results.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_edge(in_data);
        void'(pending_edges.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_edges.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_edges[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern and monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if ($urandom_range(0, 499) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        pcma_pkg::out_item_t e;
        e = expected_results.pop_front();
        if (out_data.period_us !== e.period_us)
          report_mismatch("period_us", out_data.period_us, e.period_us);
        if (out_data.avg_period_us !== e.avg_period_us)
          report_mismatch("avg_period_us", out_data.avg_period_us, e.avg_period_us);
        if (out_data.pulse_us !== e.pulse_us)
          report_mismatch("pulse_us", out_data.pulse_us, e.pulse_us);
        if (out_data.avg_pulse_us !== e.avg_pulse_us)
          report_mismatch("avg_pulse_us", out_data.avg_pulse_us, e.avg_pulse_us);
        if (out_data.avg_duty !== e.avg_duty)
          report_mismatch("avg_duty", out_data.avg_duty, e.avg_duty);
        if (out_data.duty_velocity !== e.duty_velocity)
          report_mismatch("duty_velocity", out_data.duty_velocity, e.duty_velocity);
      end
    end
    if (cycles > 64'd3000000) begin
      $display("pwm_capture_moving_average_unit: mismatch");
      $finish;
    end
  end

  function automatic pcma_pkg::in_item_t make_edge(input logic f,
                                                   input logic [pcma_pkg::TIME_BITS-1:0] t);
    pcma_pkg::in_item_t r;
    r.func = f;
    r.elapsed_us = t;
    return r;
  endfunction

  function automatic logic [pcma_pkg::TIME_BITS-1:0] rand_time();
    case ($urandom_range(0, 5))
      0: return pcma_pkg::TIME_BITS'($urandom_range(0, 3));
      1: return pcma_pkg::TIME_BITS'(24'hFFFFFF - $urandom_range(0, 3));
      2: return pcma_pkg::TIME_BITS'($urandom);
      default: return pcma_pkg::TIME_BITS'($urandom_range(100, 40000));
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_edges.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_window(input int unsigned w);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= pcma_pkg::WIN_BITS'(w);
    @(posedge clk);
    cfg_we <= 1'b0;
    win_reg = w;
  endtask

  int unsigned windows [8] = '{16, 1, 0, 31, 5, 17, 3, 16};

  initial begin
    logic [pcma_pkg::TIME_BITS-1:0] p, h;
    per_total = 0; pul_total = 0; last_per = 0; last_pul = 0;
    avg_per = 0; avg_pul = 0; slot = 0; win_reg = 16;
    duty_now = 0; duty_prev = 0; vel_now = 0;
    for (int i = 0; i < pcma_pkg::WINDOW_MAX; i++) begin
      per_ring[i] = '0;
      pul_ring[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero period, extremes, pulse longer than period
    pending_edges.push_back(make_edge(pcma_pkg::EDGE_FALL, 24'd500));
    pending_edges.push_back(make_edge(pcma_pkg::EDGE_RISE, 24'd0));
    pending_edges.push_back(make_edge(pcma_pkg::EDGE_FALL, 24'd0));
    pending_edges.push_back(make_edge(pcma_pkg::EDGE_RISE, 24'hFFFFFF));
    pending_edges.push_back(make_edge(pcma_pkg::EDGE_FALL, 24'hFFFFFF));
    pending_edges.push_back(make_edge(pcma_pkg::EDGE_RISE, 24'd1));
    pending_edges.push_back(make_edge(pcma_pkg::EDGE_FALL, 24'hFFFFFF));
    pending_edges.push_back(make_edge(pcma_pkg::EDGE_RISE, 24'd1000));
    pending_edges.push_back(make_edge(pcma_pkg::EDGE_FALL, 24'd250));
    pending_edges.push_back(make_edge(pcma_pkg::EDGE_RISE, 24'hAAAAAA));
    pending_edges.push_back(make_edge(pcma_pkg::EDGE_FALL, 24'h555555));
    wait_idle();

    foreach (windows[k]) begin
      write_window(windows[k]);
      // large window shrunk to small: slot beyond window path
      for (int n = 0; n < 230; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          pending_edges.push_back(make_edge(1'($urandom_range(0, 1)), rand_time()));
        end else begin
          p = rand_time();
          h = ($urandom_range(0, 7) == 0) ? rand_time() :
              pcma_pkg::TIME_BITS'(32'(p) * $urandom_range(0, 100) / 100);
          pending_edges.push_back(make_edge(pcma_pkg::EDGE_RISE, p));
          pending_edges.push_back(make_edge(pcma_pkg::EDGE_FALL, h));
          n++;
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("pwm_capture_moving_average_unit: match");
    end else begin
      $display("pwm_capture_moving_average_unit: mismatch");
    end
    $finish;
  end

endmodule
